// ----- src/umf_pkg.sv -----
// ----------------------------------------------------------------------------
// umf_pkg: shared types and constants for the unit-capacity max-flow block
// Sizes of the edge and vertex stores, result status codes and result type.
// ----------------------------------------------------------------------------
package umf_pkg;

  localparam int unsigned MaxVertices = 256;
  localparam int unsigned MaxEdges    = 1024;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned EdgeW       = $clog2(MaxEdges);
  localparam int unsigned CountW      = EdgeW + 1;

  typedef enum logic [1:0] {
    StStored  = 2'd0,
    StDropped = 2'd1,
    StAnswer  = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [CountW-1:0]   path_count;
  } result_t;

endpackage

// ----- src/umf_ram.sv -----
// ----------------------------------------------------------------------------
// umf_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module umf_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/umf_ctrl.sv -----
// ----------------------------------------------------------------------------
// umf_ctrl: edge table, residual search and augmentation sequencer
// Holds the edge, flow, vertex and queue memories and walks them one access
// at a time: edge appends, flow clearing, breadth-first sweeps, augmenting.
// ----------------------------------------------------------------------------
module umf_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  logic [umf_pkg::VtxW-1:0] vertex_a_i,
  input  logic [umf_pkg::VtxW-1:0] vertex_b_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output umf_pkg::result_t        res_o
);
  import umf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_POPW  = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SEV   = 4'd6;
  localparam logic [3:0] S_ARD   = 4'd7;
  localparam logic [3:0] S_AE    = 4'd8;
  localparam logic [3:0] S_AW    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam int unsigned QW = VtxW + 1;

  logic [3:0]             state_q, state_d;
  logic [CountW-1:0]      total_q, total_d;
  logic [CountW-1:0]      e_q, e_d;
  logic [QW-1:0]          head_q, head_d, tail_q, tail_d;
  logic [VtxW-1:0]        src_q, src_d, dst_q, dst_d, v_q, v_d, p_q, p_d;
  logic [EdgeW-1:0]       ae_q, ae_d;
  logic [CountW-1:0]      cnt_q, cnt_d;
  status_e                stat_q, stat_d;
  logic [MaxVertices-1:0] vis_q, vis_d;

  // Memory ports.
  logic                  edge_we, flow_we, vert_we, queue_we;
  logic [EdgeW-1:0]      edge_waddr, edge_raddr, flow_waddr;
  logic [2*VtxW-1:0]     edge_wdata, edge_rdata;
  logic [1:0]            flow_wdata, flow_rdata;
  logic [VtxW-1:0]       vert_waddr, vert_raddr, queue_waddr, queue_raddr, queue_rdata;
  logic [VtxW-1:0]       queue_wdata;
  logic [EdgeW+VtxW-1:0] vert_wdata, vert_rdata;

  logic [VtxW-1:0] ea, eb, w;
  logic            hit;

  umf_ram #(.Depth(MaxEdges), .Width(2*VtxW)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  umf_ram #(.Depth(MaxEdges), .Width(2)) u_flow (
    .clk_i, .we_i(flow_we), .waddr_i(flow_waddr), .wdata_i(flow_wdata),
    .raddr_i(edge_raddr), .rdata_o(flow_rdata)
  );
  umf_ram #(.Depth(MaxVertices), .Width(EdgeW+VtxW)) u_vert (
    .clk_i, .we_i(vert_we), .waddr_i(vert_waddr), .wdata_i(vert_wdata),
    .raddr_i(vert_raddr), .rdata_o(vert_rdata)
  );
  umf_ram #(.Depth(MaxVertices), .Width(VtxW)) u_queue (
    .clk_i, .we_i(queue_we), .waddr_i(queue_waddr), .wdata_i(queue_wdata),
    .raddr_i(queue_raddr), .rdata_o(queue_rdata)
  );

  // Queue write data: the source at search start, otherwise the new vertex.
  assign queue_wdata = (state_q == S_INIT) ? src_q : w;

  assign ea = edge_rdata[VtxW-1:0];
  assign eb = edge_rdata[2*VtxW-1:VtxW];

  // Residual neighbor test for the edge loaded during the sweep.
  always_comb begin
    hit = 1'b0;
    w   = ea;
    if (ea != eb) begin
      if (ea == v_q) begin
        hit = (flow_rdata != 2'd1);
        w   = eb;
      end else if (eb == v_q) begin
        hit = (flow_rdata != 2'd2);
        w   = ea;
      end
    end
    hit = hit && !vis_q[w];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{status: stat_q, path_count: cnt_q};

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    e_d     = e_q;
    head_d  = head_q;
    tail_d  = tail_q;
    src_d   = src_q;
    dst_d   = dst_q;
    v_d     = v_q;
    p_d     = p_q;
    ae_d    = ae_q;
    cnt_d   = cnt_q;
    stat_d  = stat_q;
    vis_d   = vis_q;

    edge_we     = 1'b0;
    edge_waddr  = total_q[EdgeW-1:0];
    edge_wdata  = {vertex_b_i, vertex_a_i};
    edge_raddr  = e_q[EdgeW-1:0];
    flow_we     = 1'b0;
    flow_waddr  = e_q[EdgeW-1:0];
    flow_wdata  = 2'd0;
    vert_we     = 1'b0;
    vert_waddr  = w;
    vert_wdata  = {e_q[EdgeW-1:0], v_q};
    vert_raddr  = v_q;
    queue_we    = 1'b0;
    queue_waddr = tail_q[VtxW-1:0];
    queue_raddr = head_q[VtxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          if (!req_type_i) begin
            state_d = S_DONE;
            if (total_q == CountW'(MaxEdges)) begin
              stat_d = StDropped;
            end else begin
              stat_d  = StStored;
              edge_we = 1'b1;
              total_d = total_q + 1'b1;
            end
          end else begin
            stat_d = StAnswer;
            src_d  = vertex_a_i;
            dst_d  = vertex_b_i;
            e_d    = '0;
            state_d = (vertex_a_i == vertex_b_i) ? S_DONE : S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        if (e_q == total_q) begin
          state_d = S_INIT;
        end else begin
          flow_we = 1'b1;
          e_d     = e_q + 1'b1;
        end
      end
      S_INIT: begin
        vis_d         = '0;
        vis_d[src_q]  = 1'b1;
        queue_we      = 1'b1;
        queue_waddr   = '0;
        head_d        = '0;
        tail_d        = QW'(1);
        state_d       = S_POP;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          state_d = S_DONE;
        end else begin
          head_d  = head_q + 1'b1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        v_d     = queue_rdata;
        e_d     = '0;
        state_d = S_SRD;
      end
      S_SRD: begin
        state_d = (e_q == total_q) ? S_POP : S_SEV;
      end
      S_SEV: begin
        e_d     = e_q + 1'b1;
        state_d = S_SRD;
        if (hit) begin
          vis_d[w] = 1'b1;
          vert_we  = 1'b1;
          if (w == dst_q) begin
            v_d     = dst_q;
            state_d = S_ARD;
          end else if (tail_q != QW'(MaxVertices)) begin
            queue_we = 1'b1;
            tail_d   = tail_q + 1'b1;
          end
        end
      end
      S_ARD: begin
        if (v_q == src_q) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_INIT;
        end else begin
          state_d = S_AE;
        end
      end
      S_AE: begin
        p_d        = vert_rdata[VtxW-1:0];
        ae_d       = vert_rdata[EdgeW+VtxW-1:VtxW];
        edge_raddr = vert_rdata[EdgeW+VtxW-1:VtxW];
        state_d    = S_AW;
      end
      S_AW: begin
        flow_we    = 1'b1;
        flow_waddr = ae_q;
        if (ea == p_q) begin
          flow_wdata = (flow_rdata == 2'd2) ? 2'd0 : 2'd1;
        end else begin
          flow_wdata = (flow_rdata == 2'd1) ? 2'd0 : 2'd2;
        end
        v_d     = p_q;
        state_d = S_ARD;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      cnt_q   <= '0;
      stat_q  <= StStored;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    head_q <= head_d;
    tail_q <= tail_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    v_q    <= v_d;
    p_q    <= p_d;
    ae_q   <= ae_d;
    vis_q  <= vis_d;
  end

endmodule

// ----- src/unit_capacity_max_flow.sv -----
// ----------------------------------------------------------------------------
// unit_capacity_max_flow: edge-disjoint path counter on an undirected graph
// Stores edges and answers source/sink queries with unit-capacity max flow.
// ----------------------------------------------------------------------------
// Input beats on s_axis: tuser = 0 appends edge (vertex_a, vertex_b) to a
// 1024-entry edge table; tuser = 1 asks for the number of edge-disjoint paths
// from vertex_a to vertex_b. Every input beat yields exactly one output beat
// on m_axis: tuser carries the status (stored, dropped because the table is
// full, or query answered) and tdata the path count (zero for edge beats).
// An edge beat takes the controller from S_IDLE to S_DONE, and no new beat is
// accepted until it is back in S_IDLE. A query first clears the flow memory
// entry by entry, one entry per stored edge, then runs breadth-first sweeps
// over the edge memory, reading every edge for each dequeued vertex, and
// walks each augmenting path back through S_ARD, S_AE and S_AW per hop; the
// single edge-memory read port serializes these edge and flow reads.
// One item is in work at a time; the result sits in an output register so
// the next item is taken while it waits. A stalled m_axis holds the result
// and, once the engine finishes, holds off s_axis. Reset empties the edge
// table and clears the output valid flag; memory contents need no clearing.
module unit_capacity_max_flow (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // vertex_a [7:0], vertex_b [15:8]
  input  logic        s_axis_tuser_i,   // req_type [0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // path_count [10:0], zero fill [15:11]
  output logic [1:0]  m_axis_tuser_o    // status [1:0]
);
  import umf_pkg::*;

  logic    res_valid, res_ready;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  umf_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .req_type_i (s_axis_tuser_i),
    .vertex_a_i (s_axis_tdata_i[7:0]),
    .vertex_b_i (s_axis_tdata_i[15:8]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.path_count};
  assign m_axis_tuser_o  = out_q.status;

endmodule
